// ===== hw/rtl/mxt_pkg.sv =====
// ----------------------------------------------------------------------------
// mxt_pkg: shared types, constants and helpers of the max-xor binary trie
// Word formats, opcodes, status codes, controller states and the saturating
// count update.
// ----------------------------------------------------------------------------
package mxt_pkg;

    localparam int KEY_BITS   = 31;
    localparam int NODE_COUNT = 65536;

    localparam int KEY_W   = 31;
    localparam int DELTA_W = 20;
    localparam int XOR_W   = 31;
    localparam int CNT_W   = 20;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int FREE_W = NODE_W + 1;
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int MISS_W = $clog2(KEY_BITS + 1);
    localparam int SUM_W  = ((CNT_W > DELTA_W) ? CNT_W : DELTA_W) + 2;

    localparam int LINKS_W  = 2 * NODE_W;
    localparam int COUNTS_W = 2 * CNT_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_ADJUST = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [KEY_W-1:0]          key;
        logic signed [DELTA_W-1:0] delta;
    } t_in_word;

    typedef struct packed {
        logic [XOR_W-1:0] best_xor;
        logic [1:0]       status;
    } t_out_word;

    // one node entry: child links and the live counts of those children
    typedef logic [1:0][NODE_W-1:0] t_links;
    typedef logic [1:0][CNT_W-1:0]  t_counts;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0]          cnt,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] lim;
        logic [CNT_W-1:0]        res;
        s   = $signed({{(SUM_W-CNT_W){1'b0}}, cnt}) + SUM_W'(d);
        lim = $signed({{(SUM_W-CNT_W){1'b0}}, {CNT_W{1'b1}}});
        if (s < 0) begin
            res = '0;
        end else if (s > lim) begin
            res = '1;
        end else begin
            res = s[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mxt_ram.sv =====
// ----------------------------------------------------------------------------
// mxt_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mxt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/max_xor_binary_trie_top.sv =====
// ----------------------------------------------------------------------------
// max_xor_binary_trie_top: bitwise trie with maximum-xor query
// Keys are walked one bit per cycle from the top bit down, one trie level per
// cycle through the node memory, whose single read port sets the pace. A query
// walks the 31 levels and then the result stage. Insert and adjust walk twice,
// a check walk and then an update walk; when the check walk rejects the word
// (pool full, key absent) the result stage follows it. Clear goes from accept
// straight to the result stage. Each node entry holds both child links and
// the live counts of those children, so a level needs one read and, in an
// update walk, one write. The root is tracked by a flag after reset and clear,
// so there is no clearing pass and the block is ready right after reset.
// ----------------------------------------------------------------------------
module max_xor_binary_trie_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mxt_pkg::t_in_word    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mxt_pkg::t_out_word   o_out_data
);

    // control state
    mxt_pkg::t_state               r_state, n_state;
    logic [mxt_pkg::FREE_W-1:0]    r_free, n_free;
    logic                          r_root_ok, n_root_ok;
    logic                          r_out_valid;

    // walk state
    mxt_pkg::t_op                  r_op, n_op;
    logic                          r_pass, n_pass;
    logic [mxt_pkg::LVL_W-1:0]     r_lvl, n_lvl;
    logic [mxt_pkg::NODE_W-1:0]    r_node, n_node;
    logic                          r_new, n_new;
    logic [mxt_pkg::MISS_W-1:0]    r_miss, n_miss;
    logic                          r_empty, n_empty;
    logic [mxt_pkg::KEY_BITS-1:0]  r_key, n_key;
    logic [mxt_pkg::KEY_BITS-1:0]  r_xor, n_xor;
    logic signed [mxt_pkg::DELTA_W-1:0] r_delta, n_delta;
    mxt_pkg::t_status              r_status, n_status;
    mxt_pkg::t_out_word            r_out;

    // memory ports
    logic                          w_we;
    logic [mxt_pkg::NODE_W-1:0]    w_raddr;
    logic [mxt_pkg::LINKS_W-1:0]   w_links_rd;
    logic [mxt_pkg::COUNTS_W-1:0]  w_counts_rd;
    mxt_pkg::t_links               w_links_wr;
    mxt_pkg::t_counts              w_counts_wr;

    // level datapath
    logic                          w_force;
    mxt_pkg::t_links               w_links;
    mxt_pkg::t_counts              w_counts;
    logic                          w_bit;
    logic [mxt_pkg::NODE_W-1:0]    w_same, w_opp;
    logic                          w_missing;
    logic [mxt_pkg::CNT_W-1:0]     w_cnt_same, w_cnt_opp, w_cnt_new;
    logic                          w_take_opp;
    logic                          w_empty_now;
    logic                          w_first, w_last;
    logic [mxt_pkg::MISS_W-1:0]    w_miss_n;
    logic                          w_full;
    logic signed [mxt_pkg::DELTA_W-1:0] w_step;
    logic [mxt_pkg::NODE_W-1:0]    w_child;
    logic                          w_child_new;
    logic                          w_slot_free;
    logic                          w_in_acc;

    mxt_ram #(
        .WIDTH (mxt_pkg::LINKS_W),
        .DEPTH (mxt_pkg::NODE_COUNT)
    ) u_links_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_node),
        .i_wdata (w_links_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_links_rd)
    );

    mxt_ram #(
        .WIDTH (mxt_pkg::COUNTS_W),
        .DEPTH (mxt_pkg::NODE_COUNT)
    ) u_counts_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_node),
        .i_wdata (w_counts_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_counts_rd)
    );

    // freshly allocated nodes and a cleared root read as empty
    assign w_force  = r_new | ((r_node == '0) & ~r_root_ok);
    assign w_links  = w_force ? '0 : w_links_rd;
    assign w_counts = w_force ? '0 : w_counts_rd;

    assign w_bit      = r_key[mxt_pkg::KEY_BITS-1];
    assign w_same     = w_links[w_bit];
    assign w_opp      = w_links[~w_bit];
    assign w_missing  = (w_same == '0);
    assign w_cnt_same = w_missing ? '0 : w_counts[w_bit];
    assign w_cnt_opp  = w_counts[~w_bit];
    assign w_take_opp = ((w_opp != '0) && (w_cnt_opp != '0)) || w_missing;
    assign w_empty_now = !(((w_links[0] != '0) && (w_counts[0] != '0)) ||
                           ((w_links[1] != '0) && (w_counts[1] != '0)));

    assign w_first  = (r_lvl == mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1));
    assign w_last   = (r_lvl == '0);
    assign w_miss_n = r_miss + mxt_pkg::MISS_W'(w_missing);
    assign w_full   = ({1'b0, r_free} + (mxt_pkg::FREE_W + 1)'(w_miss_n)) >
                      (mxt_pkg::FREE_W + 1)'(mxt_pkg::NODE_COUNT);
    assign w_step    = (r_op == mxt_pkg::OP_INSERT) ? mxt_pkg::DELTA_W'(1) : r_delta;
    assign w_cnt_new = mxt_pkg::sat_add(w_cnt_same, w_step);

    assign w_slot_free = ~r_out_valid | i_out_ready;
    assign o_in_ready  = (r_state == mxt_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid & o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_root_ok = r_root_ok;
        n_op      = r_op;
        n_pass    = r_pass;
        n_lvl     = r_lvl;
        n_node    = r_node;
        n_new     = r_new;
        n_miss    = r_miss;
        n_empty   = r_empty;
        n_key     = r_key;
        n_xor     = r_xor;
        n_delta   = r_delta;
        n_status  = r_status;
        w_we        = 1'b0;
        w_raddr     = '0;
        w_links_wr  = w_links;
        w_counts_wr = w_counts;
        w_child     = '0;
        w_child_new = 1'b0;

        unique case (r_state)
            mxt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = mxt_pkg::t_op'(i_in_data.opcode);
                    n_key    = mxt_pkg::KEY_BITS'(i_in_data.key);
                    n_delta  = i_in_data.delta;
                    n_pass   = 1'b0;
                    n_lvl    = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
                    n_node   = '0;
                    n_new    = 1'b0;
                    n_miss   = '0;
                    n_empty  = 1'b0;
                    n_xor    = '0;
                    n_status = mxt_pkg::STAT_OK;
                    if (mxt_pkg::t_op'(i_in_data.opcode) == mxt_pkg::OP_CLEAR) begin
                        n_root_ok = 1'b0;
                        n_free    = mxt_pkg::FREE_W'(1);
                        n_state   = mxt_pkg::S_FIN;
                    end else begin
                        n_state = mxt_pkg::S_WALK;
                    end
                end
            end

            mxt_pkg::S_WALK: begin
                unique case (r_op)
                    mxt_pkg::OP_QUERY: begin
                        w_child = w_take_opp ? w_opp : w_same;
                    end
                    mxt_pkg::OP_INSERT: begin
                        if (!r_pass) begin
                            w_child     = w_same;
                            w_child_new = w_missing;
                        end else begin
                            w_child     = w_missing ? r_free[mxt_pkg::NODE_W-1:0] : w_same;
                            w_child_new = w_missing;
                            w_we        = 1'b1;
                            w_links_wr[w_bit]  = w_child;
                            w_counts_wr[w_bit] = w_cnt_new;
                            n_free = r_free + mxt_pkg::FREE_W'(w_missing);
                        end
                    end
                    mxt_pkg::OP_ADJUST: begin
                        w_child     = w_same;
                        w_child_new = w_missing;
                        if (r_pass) begin
                            w_we = 1'b1;
                            w_counts_wr[w_bit] = w_cnt_new;
                        end
                    end
                    default: begin
                        w_child = '0;
                    end
                endcase

                if (w_we && (r_node == '0)) begin
                    n_root_ok = 1'b1;
                end

                n_key  = (r_key << 1) | (r_key >> (mxt_pkg::KEY_BITS - 1));
                n_xor  = (r_xor << 1) | mxt_pkg::KEY_BITS'(w_take_opp);
                n_lvl  = r_lvl - mxt_pkg::LVL_W'(1);
                n_miss = w_miss_n;
                if (w_first) begin
                    n_empty = w_empty_now;
                end

                if (w_last) begin
                    // next walk, if any, starts again at the root
                    w_raddr = '0;
                    n_node  = '0;
                    n_new   = 1'b0;
                    n_lvl   = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
                    n_miss  = '0;
                    n_state = mxt_pkg::S_FIN;
                    if (r_op == mxt_pkg::OP_QUERY) begin
                        if (w_first ? w_empty_now : r_empty) begin
                            n_status = mxt_pkg::STAT_EMPTY;
                            n_xor    = '0;
                        end
                    end else begin
                        n_xor = '0;
                        if (!r_pass) begin
                            if ((r_op == mxt_pkg::OP_INSERT) && w_full) begin
                                n_status = mxt_pkg::STAT_FULL;
                            end else if ((r_op == mxt_pkg::OP_ADJUST) && (w_miss_n != '0)) begin
                                n_status = mxt_pkg::STAT_ABSENT;
                            end else begin
                                n_pass  = 1'b1;
                                n_state = mxt_pkg::S_WALK;
                            end
                        end
                    end
                end else begin
                    w_raddr = w_child;
                    n_node  = w_child;
                    n_new   = w_child_new;
                end
            end

            mxt_pkg::S_FIN: begin
                if (w_slot_free) begin
                    n_state = mxt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mxt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mxt_pkg::S_IDLE;
            r_free    <= mxt_pkg::FREE_W'(1);
            r_root_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_root_ok <= n_root_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pass   <= n_pass;
        r_lvl    <= n_lvl;
        r_node   <= n_node;
        r_new    <= n_new;
        r_miss   <= n_miss;
        r_empty  <= n_empty;
        r_key    <= n_key;
        r_xor    <= n_xor;
        r_delta  <= n_delta;
        r_status <= n_status;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == mxt_pkg::S_FIN) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mxt_pkg::S_FIN) && w_slot_free) begin
            r_out.best_xor <= mxt_pkg::XOR_W'(r_xor);
            r_out.status   <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) &&
        ({1'b0, r_free} <= (mxt_pkg::FREE_W + 1)'(mxt_pkg::NODE_COUNT)))
        else $error("next free node out of range");

    a_write_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == mxt_pkg::S_WALK) && r_pass))
        else $error("node write outside an update walk");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !w_last) |-> (w_raddr != r_node))
        else $error("node read and write collide");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != mxt_pkg::S_IDLE))
        else $error("accepted word did not start");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mxt_pkg::S_FIN) && !w_slot_free) |=>
            ((r_state == mxt_pkg::S_FIN) && $stable(r_status)))
        else $error("finished word lost while output busy");

endmodule
